>>> src/red_pkg.sv
// ----------------------------------------------------------------------------
// red_pkg
// Shared widths, limits and stage types of the reflection extremum detector.
// ----------------------------------------------------------------------------
`default_nettype none

package red_pkg;

    localparam int MAX_TRACE_LEN = 4096;

    localparam int SAMPLE_W   = 32;
    localparam int DIFF_W     = SAMPLE_W;
    localparam int STRENGTH_W = SAMPLE_W + 1;
    localparam int POS_W      = 12;
    localparam int FOUND_W    = 12;
    localparam int COUNT_W    = $clog2(MAX_TRACE_LEN + 1);

    // Window taps: older and middle sample
    localparam int NUM_TAPS = 2;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [DIFF_W-1:0]          t_diff;
    typedef logic [STRENGTH_W-1:0]      t_strength;
    typedef logic [POS_W-1:0]           t_pos;
    typedef logic [FOUND_W-1:0]         t_found;
    typedef logic [COUNT_W-1:0]         t_count;

    // Control handed from the peak stage to the report stage
    typedef struct packed {
        logic valid;     // a beat occupies the stage
        logic extremum;  // middle sample tested and found a strict extremum
        logic last;      // beat closed its trace
        t_pos pos;       // index of the middle sample
    } t_peak_info;

endpackage

`default_nettype wire

>>> src/red_tap_cell.sv
// ----------------------------------------------------------------------------
// red_tap_cell
// One window cell: holds a sample and hands it to its neighbor on shift.
// ----------------------------------------------------------------------------
`default_nettype none

module red_tap_cell (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_shift,
    input  wire              i_clear,
    input  red_pkg::t_sample i_sample,
    output red_pkg::t_sample o_sample
);
    import red_pkg::*;

    t_sample r_sample;
    t_sample n_sample;

    always_comb begin
        n_sample = r_sample;
        if (i_clear) begin
            n_sample = '0;
        end else if (i_shift) begin
            n_sample = i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample <= '0;
        end else begin
            r_sample <= n_sample;
        end
    end

    assign o_sample = r_sample;

endmodule

`default_nettype wire

>>> src/red_peak_stage.sv
// ----------------------------------------------------------------------------
// red_peak_stage
// First stage: strict extremum test and absolute neighbor differences.
// ----------------------------------------------------------------------------
`default_nettype none

module red_peak_stage (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_advance,
    input  wire                 i_accept,
    input  wire                 i_last,
    input  red_pkg::t_count     i_count,
    input  red_pkg::t_sample    i_older,
    input  red_pkg::t_sample    i_middle,
    input  red_pkg::t_sample    i_newest,
    output red_pkg::t_peak_info o_info,
    output red_pkg::t_diff      o_diff_older,
    output red_pkg::t_diff      o_diff_newest
);
    import red_pkg::*;

    t_peak_info r_info;
    t_peak_info n_info;
    t_diff      r_diff_older;
    t_diff      r_diff_newest;
    t_diff      n_diff_older;
    t_diff      n_diff_newest;

    logic                  gt_older, gt_newest, lt_older, lt_newest;
    logic                  tested;
    logic signed [DIFF_W:0] sub_older, sub_newest;
    t_count                pos_full;

    always_comb begin
        gt_older  = i_middle > i_older;
        lt_older  = i_middle < i_older;
        gt_newest = i_middle > i_newest;
        lt_newest = i_middle < i_newest;

        sub_older  = {i_middle[SAMPLE_W-1], i_middle} - {i_older[SAMPLE_W-1], i_older};
        sub_newest = {i_middle[SAMPLE_W-1], i_middle} - {i_newest[SAMPLE_W-1], i_newest};
        n_diff_older  = sub_older[DIFF_W]  ? DIFF_W'(-sub_older)  : sub_older[DIFF_W-1:0];
        n_diff_newest = sub_newest[DIFF_W] ? DIFF_W'(-sub_newest) : sub_newest[DIFF_W-1:0];

        // middle is testable only with two neighbors and inside the length limit
        tested   = (i_count >= COUNT_W'(2)) && (i_count < COUNT_W'(MAX_TRACE_LEN));
        pos_full = i_count - COUNT_W'(1);

        n_info.valid    = i_accept;
        n_info.extremum = tested && ((gt_older && gt_newest) || (lt_older && lt_newest));
        n_info.last     = i_last;
        n_info.pos      = pos_full[POS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_info.valid <= 1'b0;
        end else if (i_advance) begin
            r_info.valid <= n_info.valid;
        end
        if (i_advance) begin
            r_info.extremum <= n_info.extremum;
            r_info.last     <= n_info.last;
            r_info.pos      <= n_info.pos;
            r_diff_older    <= n_diff_older;
            r_diff_newest   <= n_diff_newest;
        end
    end

    assign o_info        = r_info;
    assign o_diff_older  = r_diff_older;
    assign o_diff_newest = r_diff_newest;

endmodule

`default_nettype wire

>>> src/red_report_stage.sv
// ----------------------------------------------------------------------------
// red_report_stage
// Second stage: strength sum, threshold compare, reflection count, output reg.
// ----------------------------------------------------------------------------
`default_nettype none

module red_report_stage (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_advance,
    input  red_pkg::t_peak_info i_info,
    input  red_pkg::t_diff      i_diff_older,
    input  red_pkg::t_diff      i_diff_newest,
    input  red_pkg::t_strength  i_threshold,
    output logic                o_valid,
    output red_pkg::t_pos       o_position,
    output red_pkg::t_strength  o_strength,
    output red_pkg::t_found     o_reflection_number
);
    import red_pkg::*;

    logic      r_valid;
    t_found    r_found;
    t_found    n_found;
    t_pos      r_position;
    t_strength r_strength;
    t_found    r_number;

    t_strength sum;
    logic      hit;

    always_comb begin
        sum = {1'b0, i_diff_older} + {1'b0, i_diff_newest};
        hit = i_info.valid && i_info.extremum && (sum >= i_threshold);

        n_found = r_found;
        if (hit) begin
            n_found = r_found + FOUND_W'(1);
        end
        // trace end restarts the count after its own result
        if (i_info.valid && i_info.last) begin
            n_found = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_found <= '0;
        end else if (i_advance) begin
            r_valid <= hit;
            r_found <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && hit) begin
            r_position <= i_info.pos;
            r_strength <= sum;
            r_number   <= r_found;
        end
    end

    assign o_valid             = r_valid;
    assign o_position          = r_position;
    assign o_strength          = r_strength;
    assign o_reflection_number = r_number;

endmodule

`default_nettype wire

>>> src/reflection_extremum_detector_core.sv
// ----------------------------------------------------------------------------
// reflection_extremum_detector_core
// Reports strict local extrema of an impedance profile above a threshold.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one signed Q16.16 sample
//   per beat plus i_trace_end on the last sample of a trace. Output channel
//   (o_out_valid / i_out_ready) carries position, strength and reflection
//   number of the middle sample of the three-sample window when it is a
//   strict extremum with strength >= threshold. Config channel
//   (i_cfg_valid / o_cfg_ready) writes the 33-bit threshold; always ready,
//   write only while no beat is in flight.
//   Throughput: one sample per cycle while the receiver does not stall.
//   The window is two tap cells that shift each beat taken below the length
//   limit; the peak stage and then the report stage register a result once
//   the beat that holds the right neighbor is accepted.
//   Reset (synchronous, active low) clears window, counters, threshold and
//   both stage valids. When the receiver stalls, the output register holds
//   its beat and o_in_ready drops, freezing the whole pipeline; the next
//   result can be offered in the cycle after the held one is accepted.
//   Samples past the length limit of a trace are dropped until trace end.
// ----------------------------------------------------------------------------
`default_nettype none

module reflection_extremum_detector_core (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  red_pkg::t_sample   i_sample,
    input  wire                i_trace_end,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output red_pkg::t_pos      o_position,
    output red_pkg::t_strength o_strength,
    output red_pkg::t_found    o_reflection_number,
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  red_pkg::t_strength i_cfg_threshold
);
    import red_pkg::*;

    logic       advance;
    logic       accept;
    logic       take;
    t_count     r_sample_count;
    t_count     n_sample_count;
    t_strength  r_threshold;
    t_sample    taps [NUM_TAPS+1];
    t_peak_info peak_info;
    t_diff      diff_older;
    t_diff      diff_newest;

    // advance the pipeline unless a result is held
    assign advance     = !o_out_valid || i_out_ready;
    assign o_in_ready  = advance;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && advance;
    assign take        = accept && (r_sample_count < COUNT_W'(MAX_TRACE_LEN));

    always_comb begin
        n_sample_count = r_sample_count;
        if (accept) begin
            if (i_trace_end) begin
                n_sample_count = '0;
            end else if (take) begin
                n_sample_count = r_sample_count + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= '0;
            r_threshold    <= '0;
        end else begin
            r_sample_count <= n_sample_count;
            if (i_cfg_valid) begin
                r_threshold <= i_cfg_threshold;
            end
        end
    end

    // taps[0] is the newest sample, taps[NUM_TAPS] the oldest
    assign taps[0] = i_sample;

    genvar g;
    generate
        for (g = 0; g < NUM_TAPS; g++) begin : g_tap
            red_tap_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_shift  (take),
                .i_clear  (accept && i_trace_end),
                .i_sample (taps[g]),
                .o_sample (taps[g+1])
            );
        end
    endgenerate

    red_peak_stage u_peak (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (advance),
        .i_accept      (accept),
        .i_last        (i_trace_end),
        .i_count       (r_sample_count),
        .i_older       (taps[2]),
        .i_middle      (taps[1]),
        .i_newest      (taps[0]),
        .o_info        (peak_info),
        .o_diff_older  (diff_older),
        .o_diff_newest (diff_newest)
    );

    red_report_stage u_report (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_advance           (advance),
        .i_info              (peak_info),
        .i_diff_older        (diff_older),
        .i_diff_newest       (diff_newest),
        .i_threshold         (r_threshold),
        .o_valid             (o_out_valid),
        .o_position          (o_position),
        .o_strength          (o_strength),
        .o_reflection_number (o_reflection_number)
    );

endmodule

`default_nettype wire

>>> src/red_checker.sv
// ----------------------------------------------------------------------------
// red_checker
// Port-level checks of the reflection extremum detector, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module red_checker (
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                o_in_ready,
    input wire                o_out_valid,
    input wire                i_out_ready,
    input red_pkg::t_pos      o_position,
    input red_pkg::t_strength o_strength,
    input red_pkg::t_found    o_reflection_number
);
    import red_pkg::*;

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_position) &&
        $stable(o_strength) && $stable(o_reflection_number))
        else $error("result beat changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // with the output register empty the input side must not stall
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled while output empty");

    // a strict extremum differs from each neighbor by at least one lsb
    a_min_strength: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_strength >= STRENGTH_W'(2))
        else $error("reported strength below strict extremum minimum");

endmodule

bind reflection_extremum_detector_core red_checker u_red_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .o_in_ready          (o_in_ready),
    .o_out_valid         (o_out_valid),
    .i_out_ready         (i_out_ready),
    .o_position          (o_position),
    .o_strength          (o_strength),
    .o_reflection_number (o_reflection_number)
);

`default_nettype wire
